// ===== rtl/cfra_pkg.sv =====
package cfra_pkg;

  localparam int FRAC_BITS_DEF = 32;
  localparam int TERM_BITS     = 31;
  localparam logic [TERM_BITS-1:0] TERM_LIMIT = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ITER     = 2'd2
  } status_code_t;

  typedef enum logic [0:0] {
    REG_EPSILON  = 1'b0,
    REG_MAX_ITER = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL1_INIT,
    OP_MUL1_STEP,
    OP_MUL2_INIT,
    OP_MUL2_STEP,
    OP_ADVANCE,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    FIN_OVF,
    FIN_NEAR,
    FIN_CUR,
    FIN_EVAL
  } fin_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_TOP,
    S_DIV,
    S_M1I,
    S_M1,
    S_CHK1,
    S_M2,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    fin_t fin;
  } cmd_t;

  typedef struct packed {
    logic big;
    logic near;
    logic y_zero;
    logic ovf;
    logic keep;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/cfra_ctrl.sv =====
module cfra_ctrl
  import cfra_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t sts,
  output cmd_t       cmd
);

  localparam int W     = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1) + 1;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  fin_t             fin_r, fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fin_r   <= FIN_OVF;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    cmd.op    = OP_NONE;
    cmd.fin   = fin_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.big) begin
          fin_nxt   = FIN_OVF;
          state_nxt = S_DONE;
        end else if (sts.near) begin
          fin_nxt   = FIN_NEAR;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        if (sts.y_zero) begin
          fin_nxt   = FIN_CUR;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_DIV_INIT;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_M1I;
      end
      S_M1I: begin
        cmd.op    = OP_MUL1_INIT;
        cnt_nxt   = CNT_W'(W - 1);
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op  = OP_MUL1_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_CHK1;
      end
      S_CHK1: begin
        if (sts.ovf) begin
          fin_nxt   = FIN_OVF;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_MUL2_INIT;
          cnt_nxt   = CNT_W'(TERM_BITS - 1);
          state_nxt = S_M2;
        end
      end
      S_M2: begin
        cmd.op  = OP_MUL2_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.keep) begin
          cmd.op    = OP_ADVANCE;
          state_nxt = S_TOP;
        end else begin
          fin_nxt   = FIN_EVAL;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/cfra_datapath.sv =====
module cfra_datapath
  import cfra_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] in_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  cmd_t        cmd,
  output dp_status_t  sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata
);

  localparam int W  = FRAC_BITS + 1;
  localparam int SH = 32 - FRAC_BITS;
  localparam int TB = TERM_BITS;

  logic [31:0]   eps_r;
  logic [6:0]    maxit_r;
  logic          out_valid_r;
  logic [31:0]   out_num_r;
  logic [TB-1:0] out_den_r;
  logic [1:0]    out_st_r;

  logic          neg_r;
  logic [63:0]   mag_r;
  logic [W-1:0]  x_r, y_r, rem_r, dvd_r, a_sh_r;
  logic [TB-1:0] p0_r, p1_r, q0_r, q1_r, f0_r, f1_r, q_sh_r;
  logic [63:0]   acc_p_r, acc_q_r, acc_f_r, m_p_r, m_q_r, m_f_r;
  logic [63:0]   rhs_r, epq_r, mf_r, me_r;
  logic [6:0]    n_r;

  logic [63:0]          mag_in, a0_in, lhs, diff, sdiff;
  logic [FRAC_BITS-1:0] frac_c;
  logic [W:0]           tr, sub;
  logic                 ge, far;
  logic [TB-1:0]        rn, rd;
  logic [1:0]           st;

  assign mag_in = in_tdata[63] ? (64'd0 - in_tdata) : in_tdata;
  assign a0_in  = mag_in >> FRAC_BITS;
  assign frac_c = mag_r[FRAC_BITS-1:0];

  assign tr  = {rem_r, dvd_r[W-1]};
  assign ge  = tr >= {1'b0, y_r};
  assign sub = tr - {1'b0, y_r};

  assign lhs   = acc_f_r << FRAC_BITS;
  assign diff  = (lhs > rhs_r) ? (lhs - rhs_r) : (rhs_r - lhs);
  assign sdiff = diff << SH;
  assign far   = sdiff > epq_r;

  assign sts.big      = (mag_r >> FRAC_BITS) > 64'(TERM_LIMIT);
  assign sts.near     = ((32'(frac_c)) << SH) < eps_r;
  assign sts.y_zero   = (y_r == '0);
  assign sts.ovf      = (acc_p_r > 64'(TERM_LIMIT)) || (acc_q_r > 64'(TERM_LIMIT));
  assign sts.keep     = (n_r < maxit_r) && far && (acc_q_r < 64'(TERM_LIMIT));
  assign sts.out_busy = out_valid_r && !out_tready;

  always_comb begin
    rn = '0;
    rd = '0;
    st = ST_OK;
    unique case (cmd.fin)
      FIN_OVF:  st = ST_OVERFLOW;
      FIN_NEAR: begin
        rn = mag_r[FRAC_BITS +: TB];
        rd = TB'(1);
      end
      FIN_CUR: begin
        rn = p1_r;
        rd = q1_r;
      end
      FIN_EVAL: begin
        if (n_r >= maxit_r) begin
          st = ST_ITER;
        end else if (acc_q_r < 64'(TERM_LIMIT)) begin
          rn = acc_p_r[TB-1:0];
          rd = acc_q_r[TB-1:0];
        end else begin
          rn = p1_r;
          rd = q1_r;
        end
      end
      default: st = ST_OVERFLOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= 32'd4295;
      maxit_r     <= 7'd32;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EPSILON:  eps_r   <= cfg_wdata;
          REG_MAX_ITER: maxit_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        neg_r <= in_tdata[63];
        mag_r <= mag_in;
        x_r   <= W'(1) << FRAC_BITS;
        y_r   <= W'(mag_in[FRAC_BITS-1:0]);
        p0_r  <= TB'(1);
        q0_r  <= '0;
        f0_r  <= TB'(1);
        p1_r  <= a0_in[TB-1:0];
        q1_r  <= TB'(1);
        f1_r  <= '0;
        n_r   <= '0;
      end
      OP_DIV_INIT: begin
        rem_r <= '0;
        dvd_r <= x_r;
        n_r   <= n_r + 1'b1;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? sub[W-1:0] : tr[W-1:0];
        dvd_r <= {dvd_r[W-2:0], ge};
      end
      OP_MUL1_INIT: begin
        x_r     <= y_r;
        y_r     <= rem_r;
        a_sh_r  <= dvd_r;
        acc_p_r <= 64'(p0_r);
        acc_q_r <= 64'(q0_r);
        acc_f_r <= 64'(f0_r);
        m_p_r   <= 64'(p1_r);
        m_q_r   <= 64'(q1_r);
        m_f_r   <= 64'(f1_r);
      end
      OP_MUL1_STEP: begin
        if (a_sh_r[0]) begin
          acc_p_r <= acc_p_r + m_p_r;
          acc_q_r <= acc_q_r + m_q_r;
          acc_f_r <= acc_f_r + m_f_r;
        end
        m_p_r  <= m_p_r << 1;
        m_q_r  <= m_q_r << 1;
        m_f_r  <= m_f_r << 1;
        a_sh_r <= a_sh_r >> 1;
      end
      OP_MUL2_INIT: begin
        q_sh_r <= acc_q_r[TB-1:0];
        rhs_r  <= '0;
        epq_r  <= '0;
        mf_r   <= 64'(frac_c);
        me_r   <= 64'(eps_r);
      end
      OP_MUL2_STEP: begin
        if (q_sh_r[0]) begin
          rhs_r <= rhs_r + mf_r;
          epq_r <= epq_r + me_r;
        end
        mf_r   <= mf_r << 1;
        me_r   <= me_r << 1;
        q_sh_r <= q_sh_r >> 1;
      end
      OP_ADVANCE: begin
        p0_r <= p1_r;
        q0_r <= q1_r;
        f0_r <= f1_r;
        p1_r <= acc_p_r[TB-1:0];
        q1_r <= acc_q_r[TB-1:0];
        f1_r <= acc_f_r[TB-1:0];
      end
      OP_OUT: begin
        out_num_r <= neg_r ? (32'd0 - 32'(rn)) : 32'(rn);
        out_den_r <= rd;
        out_st_r  <= st;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_st_r, out_den_r, out_num_r};

`ifndef NO_ASSERTIONS
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");
  a_st_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_st_r != 2'd3))
    else $error("illegal status code");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r != ST_OK)) |-> ((out_num_r == '0) && (out_den_r == '0)))
    else $error("failed request with nonzero result");
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == ST_OK)) |-> (out_den_r != '0))
    else $error("zero denominator on success");
`endif

endmodule

// ===== rtl/continued_fraction_rational_approx_unit.sv =====
// Channel   Dir  Handshake          Payload
// in_*      in   tvalid/tready      tdata[63:0]: value
// out_*     out  tvalid/tready      tdata[71:0]: numerator, denominator, status
// cfg_*     in   we                 index selects register, wdata[31:0]
// Each continued-fraction term of a request runs through a bit-serial divider and
// two bit-serial multipliers.
// Reset is synchronous and active low and restores the register defaults.
// A new request is taken while a finished result still waits on the output.
// A stalled output keeps the next result waiting in the done state until the register frees.
module continued_fraction_rational_approx_unit
  import cfra_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[63:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // numerator[31:0], denominator[62:32], status[64:63]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t       cmd;
  dp_status_t sts;

  cfra_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfra_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
